// ----- rtl/core/ppc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared widths, types and codes of the polygon pole containment block.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int LON_W      = 27;
    localparam int LAT_W      = 24;
    localparam int TOL_W      = 25;
    // holds half a turn either way for up to 20 fraction bits
    localparam int DIFF_W     = LON_W + 2;
    // wide enough for a longitude difference plus half a turn
    localparam int WRAP_W     = LON_W + 3;
    localparam int LSUM_W     = LAT_W + 1;
    localparam int PROD_W     = DIFF_W + LSUM_W;
    localparam int STEP_SUM_W = 40;
    localparam int AREA_W     = 64;
    localparam int TOL_RESET  = 65536;

    // a full turn is 45 << 3 degrees, half a turn 180 degrees
    localparam int HALF_TURN_DEG = 180;
    localparam int MOD_BASE      = 45;
    localparam int MOD_SHIFT     = 3;
    localparam int REM_W         = 6;

    typedef logic signed [LON_W-1:0]      lon_t;
    typedef logic signed [LAT_W-1:0]      lat_t;
    typedef logic        [TOL_W-1:0]      tol_t;
    typedef logic signed [DIFF_W-1:0]     step_t;
    typedef logic signed [LSUM_W-1:0]     lat_sum_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [STEP_SUM_W-1:0] step_sum_t;
    typedef logic signed [AREA_W-1:0]     area_t;

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } pole_code_t;

    typedef struct packed {
        logic has_edge;
        logic last;
    } vtx_ctl_t;

    typedef struct packed {
        logic      ovf;
        step_sum_t value;
    } step_acc_t;

    typedef struct packed {
        logic  ovf;
        area_t value;
    } area_acc_t;

endpackage

// ----- rtl/core/ppc_vertex_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_vertex_if
// Valid/ready channel carrying one polygon vertex word.
// ----------------------------------------------------------------------------
interface ppc_vertex_if;
    import ppc_pkg::*;

    logic valid;
    logic ready;
    lon_t vertex_lon;
    lat_t vertex_lat;
    logic is_last;

    modport source (output valid, output vertex_lon, output vertex_lat, output is_last,
                    input ready);
    modport sink   (input valid, input vertex_lon, input vertex_lat, input is_last,
                    output ready);
endinterface

// ----- rtl/core/ppc_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_result_if
// Valid/ready channel carrying one pole decision word.
// ----------------------------------------------------------------------------
interface ppc_result_if;
    import ppc_pkg::*;

    logic       valid;
    logic       ready;
    pole_code_t pole_code;
    logic       saturated;

    modport source (output valid, output pole_code, output saturated, input ready);
    modport sink   (input valid, input pole_code, input saturated, output ready);
endinterface

// ----- rtl/core/polygon_pole_containment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_pole_containment
// Streams polygon vertices and tells whether the ring encloses a pole.
//
// vertex channel: one word per vertex (longitude, latitude, is_last), taken
// when valid and ready are both high. Every edge's longitude step is unwrapped
// into half a turn either way and summed; the trapezoid term is summed too.
// result channel: one word per polygon, on its last vertex: pole code and a
// flag telling that a sum clamped somewhere in this polygon.
// cfg_we/cfg_wdata write ring_tolerance (reset 65536); write it only while
// the block is idle.
// throughput: one vertex per clock while the result channel does not stall;
// the eight-stage pipe (input, unwrap offset, reciprocal multiply, remainder,
// trapezoid multiply, accumulate, closing edge, decision) holds one word per
// stage, and the running sums take each vertex's edge as it advances.
// a stalled result register does not block the input until all stages fill;
// bubbles collapse as the pipe advances stage by stage.
// reset clears the pipe, the held vertex and the sums, and reloads the
// tolerance; a polygon in flight is dropped.
// ----------------------------------------------------------------------------
module polygon_pole_containment #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  ppc_pkg::tol_t      cfg_wdata,
    ppc_vertex_if.sink         vertex,
    ppc_result_if.source       result
);
    import ppc_pkg::*;

    localparam int NSTAGE    = 8;
    localparam int LOW_W     = COORD_FRAC_BITS + MOD_SHIFT;
    localparam int HI_W      = WRAP_W - LOW_W;
    localparam int U_W       = HI_W + 1;
    localparam int U_OFF     = MOD_BASE * ((2**(HI_W-1) + MOD_BASE - 1) / MOD_BASE);
    // u < 2^U_W, so the reciprocal error stays under 2^-6 and the quotient is exact
    localparam int REC_SHIFT = U_W + 6;
    localparam int REC_MUL   = (2**REC_SHIFT + MOD_BASE - 1) / MOD_BASE;
    localparam int REC_W     = REC_SHIFT - 5;
    localparam int Q_W       = U_W - 5;
    localparam logic signed [WRAP_W-1:0] HALF =
        WRAP_W'(HALF_TURN_DEG) <<< COORD_FRAC_BITS;

    function automatic step_acc_t add_step(step_sum_t acc, step_t step);
        logic signed [STEP_SUM_W:0] wide;
        step_acc_t                  r;
        wide  = (STEP_SUM_W+1)'(acc) + (STEP_SUM_W+1)'(step);
        r.ovf = wide[STEP_SUM_W] ^ wide[STEP_SUM_W-1];
        if (r.ovf)
        begin
            r.value = wide[STEP_SUM_W] ? {1'b1, {(STEP_SUM_W-1){1'b0}}}
                                       : {1'b0, {(STEP_SUM_W-1){1'b1}}};
        end
        else
        begin
            r.value = wide[STEP_SUM_W-1:0];
        end
        return r;
    endfunction

    function automatic area_acc_t add_area(area_t acc, prod_t prod);
        logic signed [AREA_W:0] wide;
        area_acc_t              r;
        wide  = (AREA_W+1)'(acc) + (AREA_W+1)'(prod);
        r.ovf = wide[AREA_W] ^ wide[AREA_W-1];
        if (r.ovf)
        begin
            r.value = wide[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}}
                                   : {1'b0, {(AREA_W-1){1'b1}}};
        end
        else
        begin
            r.value = wide[AREA_W-1:0];
        end
        return r;
    endfunction

    // pipe control
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;
    logic              in_accept;
    logic              acc_load;

    // config and polygon state
    tol_t      tol_reg;
    lon_t      first_lon_reg;
    lat_t      first_lat_reg;
    lon_t      prev_lon_reg;
    lat_t      prev_lat_reg;
    logic      have_prev_reg;
    step_sum_t lon_sum_reg;
    area_t     area_sum_reg;
    logic      sat_seen_reg;

    // lane 0: previous to current vertex, lane 1: current back to first
    vtx_ctl_t  s1_ctl_reg;
    lon_t      s1_from_lon_reg [2];
    lon_t      s1_to_lon_reg   [2];
    lat_t      s1_from_lat_reg [2];
    lat_t      s1_to_lat_reg   [2];

    vtx_ctl_t                   s2_ctl_reg;
    logic        [U_W-1:0]      s2_u_reg    [2];
    logic        [LOW_W-1:0]    s2_low_reg  [2];
    logic                       s2_dpos_reg [2];
    lat_sum_t                   s2_lsum_reg [2];
    logic signed [WRAP_W-1:0]   diff_next   [2];
    logic signed [WRAP_W-1:0]   wrap_next   [2];
    logic        [U_W-1:0]      u_next      [2];

    vtx_ctl_t                   s3_ctl_reg;
    logic        [Q_W-1:0]      s3_q_reg    [2];
    logic        [U_W-1:0]      s3_u_reg    [2];
    logic        [LOW_W-1:0]    s3_low_reg  [2];
    logic                       s3_dpos_reg [2];
    lat_sum_t                   s3_lsum_reg [2];
    logic        [U_W+REC_W-1:0] recip_next [2];

    vtx_ctl_t                   s4_ctl_reg;
    step_t                      s4_step_reg [2];
    lat_sum_t                   s4_lsum_reg [2];
    logic        [REM_W-1:0]    rem_next    [2];
    logic signed [WRAP_W-1:0]   mod_next    [2];
    logic signed [WRAP_W-1:0]   step_next   [2];

    vtx_ctl_t  s5_ctl_reg;
    step_t     s5_step_reg [2];
    prod_t     s5_prod_reg [2];

    vtx_ctl_t  s6_ctl_reg;
    step_sum_t s6_lon_reg;
    area_t     s6_area_reg;
    logic      s6_sat_reg;
    step_t     s6_step_reg;
    prod_t     s6_prod_reg;
    step_acc_t acc0_step;
    area_acc_t acc0_area;
    step_sum_t lon_sum_next;
    area_t     area_sum_next;
    logic      sat_seen_next;

    vtx_ctl_t  s7_ctl_reg;
    step_sum_t s7_lon_reg;
    area_t     s7_area_reg;
    logic      s7_sat_reg;
    step_acc_t acc1_step;
    area_acc_t acc1_area;

    pole_code_t res_code_reg;
    logic       res_sat_reg;
    logic [STEP_SUM_W-1:0] mag_next;
    pole_code_t code_next;

    // stage advance: a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || result.ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        in_accept = vertex.valid && adv[0];
        valid_next[0] = adv[0] ? vertex.valid : valid_reg[0];
        for (int i = 1; i < NSTAGE - 1; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
        // only the last vertex of a polygon leaves a result word
        valid_next[NSTAGE-1] = adv[NSTAGE-1] ? (valid_reg[NSTAGE-2] && s7_ctl_reg.last)
                                             : valid_reg[NSTAGE-1];
        acc_load = adv[5] && valid_reg[4];
    end

    assign vertex.ready     = adv[0];
    assign result.valid     = valid_reg[NSTAGE-1];
    assign result.pole_code = res_code_reg;
    assign result.saturated = res_sat_reg;

    // unwrap: remainder of (d + half) by a full turn, split into low bits and mod 45
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            diff_next[k]  = WRAP_W'(s1_from_lon_reg[k]) - WRAP_W'(s1_to_lon_reg[k]);
            wrap_next[k]  = diff_next[k] + HALF;
            u_next[k]     = U_W'($signed(wrap_next[k][WRAP_W-1:LOW_W])) + U_W'(U_OFF);
            recip_next[k] = (U_W+REC_W)'(s2_u_reg[k]) * (U_W+REC_W)'(REC_MUL);
            rem_next[k]   = REM_W'(s3_u_reg[k] - U_W'(s3_q_reg[k]) * U_W'(MOD_BASE));
            mod_next[k]   = WRAP_W'({rem_next[k], s3_low_reg[k]});
            // a positive step that is an odd multiple of half a turn folds to +half, else to -half
            if (mod_next[k] == '0 && s3_dpos_reg[k])
            begin
                step_next[k] = HALF;
            end
            else
            begin
                step_next[k] = mod_next[k] - HALF;
            end
        end
    end

    // running sums take the edge from the previous vertex
    always_comb
    begin
        acc0_step     = add_step(lon_sum_reg, s5_step_reg[0]);
        acc0_area     = add_area(area_sum_reg, s5_prod_reg[0]);
        lon_sum_next  = lon_sum_reg;
        area_sum_next = area_sum_reg;
        sat_seen_next = sat_seen_reg;
        if (s5_ctl_reg.has_edge)
        begin
            lon_sum_next  = acc0_step.value;
            area_sum_next = acc0_area.value;
            sat_seen_next = sat_seen_reg || acc0_step.ovf || acc0_area.ovf;
        end
        acc1_step = add_step(s6_lon_reg, s6_step_reg);
        acc1_area = add_area(s6_area_reg, s6_prod_reg);
    end

    // decision on the closed ring
    always_comb
    begin
        mag_next = s7_lon_reg[STEP_SUM_W-1] ? STEP_SUM_W'(-s7_lon_reg)
                                            : STEP_SUM_W'(s7_lon_reg);
        if (!s7_ctl_reg.has_edge || mag_next < STEP_SUM_W'(tol_reg))
        begin
            code_next = POLE_NONE;
        end
        else if (s7_area_reg[AREA_W-1])
        begin
            code_next = POLE_SOUTH;
        end
        else
        begin
            code_next = POLE_NORTH;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            tol_reg       <= TOL_W'(TOL_RESET);
            have_prev_reg <= 1'b0;
            lon_sum_reg   <= '0;
            area_sum_reg  <= '0;
            sat_seen_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (in_accept)
            begin
                have_prev_reg <= !vertex.is_last;
            end
            if (acc_load)
            begin
                if (s5_ctl_reg.last)
                begin
                    lon_sum_reg  <= '0;
                    area_sum_reg <= '0;
                    sat_seen_reg <= 1'b0;
                end
                else
                begin
                    lon_sum_reg  <= lon_sum_next;
                    area_sum_reg <= area_sum_next;
                    sat_seen_reg <= sat_seen_next;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prev_lon_reg <= vertex.vertex_lon;
            prev_lat_reg <= vertex.vertex_lat;
            if (!have_prev_reg)
            begin
                first_lon_reg <= vertex.vertex_lon;
                first_lat_reg <= vertex.vertex_lat;
            end
        end
        if (adv[0])
        begin
            s1_ctl_reg.has_edge <= have_prev_reg;
            s1_ctl_reg.last     <= vertex.is_last;
            s1_from_lon_reg[0]  <= prev_lon_reg;
            s1_from_lat_reg[0]  <= prev_lat_reg;
            s1_to_lon_reg[0]    <= vertex.vertex_lon;
            s1_to_lat_reg[0]    <= vertex.vertex_lat;
            s1_from_lon_reg[1]  <= vertex.vertex_lon;
            s1_from_lat_reg[1]  <= vertex.vertex_lat;
            s1_to_lon_reg[1]    <= have_prev_reg ? first_lon_reg : vertex.vertex_lon;
            s1_to_lat_reg[1]    <= have_prev_reg ? first_lat_reg : vertex.vertex_lat;
        end
        if (adv[1])
        begin
            s2_ctl_reg <= s1_ctl_reg;
            for (int k = 0; k < 2; k++)
            begin
                s2_u_reg[k]    <= u_next[k];
                s2_low_reg[k]  <= wrap_next[k][LOW_W-1:0];
                s2_dpos_reg[k] <= !diff_next[k][WRAP_W-1] && (diff_next[k] != '0);
                s2_lsum_reg[k] <= LSUM_W'(s1_from_lat_reg[k]) + LSUM_W'(s1_to_lat_reg[k]);
            end
        end
        if (adv[2])
        begin
            s3_ctl_reg <= s2_ctl_reg;
            for (int k = 0; k < 2; k++)
            begin
                s3_q_reg[k]    <= recip_next[k][U_W+REC_W-1:REC_SHIFT];
                s3_u_reg[k]    <= s2_u_reg[k];
                s3_low_reg[k]  <= s2_low_reg[k];
                s3_dpos_reg[k] <= s2_dpos_reg[k];
                s3_lsum_reg[k] <= s2_lsum_reg[k];
            end
        end
        if (adv[3])
        begin
            s4_ctl_reg <= s3_ctl_reg;
            for (int k = 0; k < 2; k++)
            begin
                s4_step_reg[k] <= DIFF_W'(step_next[k]);
                s4_lsum_reg[k] <= s3_lsum_reg[k];
            end
        end
        if (adv[4])
        begin
            s5_ctl_reg <= s4_ctl_reg;
            for (int k = 0; k < 2; k++)
            begin
                s5_step_reg[k] <= s4_step_reg[k];
                s5_prod_reg[k] <= PROD_W'(s4_step_reg[k]) * PROD_W'(s4_lsum_reg[k]);
            end
        end
        if (adv[5])
        begin
            s6_ctl_reg  <= s5_ctl_reg;
            s6_lon_reg  <= lon_sum_next;
            s6_area_reg <= area_sum_next;
            s6_sat_reg  <= sat_seen_next;
            s6_step_reg <= s5_step_reg[1];
            s6_prod_reg <= s5_prod_reg[1];
        end
        if (adv[6])
        begin
            s7_ctl_reg <= s6_ctl_reg;
            if (s6_ctl_reg.has_edge)
            begin
                s7_lon_reg  <= acc1_step.value;
                s7_area_reg <= acc1_area.value;
                s7_sat_reg  <= s6_sat_reg || acc1_step.ovf || acc1_area.ovf;
            end
            else
            begin
                s7_lon_reg  <= s6_lon_reg;
                s7_area_reg <= s6_area_reg;
                s7_sat_reg  <= s6_sat_reg;
            end
        end
        if (adv[7])
        begin
            res_code_reg <= code_next;
            res_sat_reg  <= s7_sat_reg;
        end
    end

endmodule

// ----- rtl/core/ppc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_checker
// Port-level checks on the polygon pole containment block.
// ----------------------------------------------------------------------------
module ppc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] pole_code,
    input logic       saturated
);
    import ppc_pkg::*;

    // only the three defined pole codes leave the block
    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pole_code == POLE_NONE || pole_code == POLE_NORTH ||
                       pole_code == POLE_SOUTH))
        else $error("undefined pole code on result");

    // with the result register empty the whole pipe can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("vertex channel blocked while result register empty");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pole_code) && $stable(saturated))
        else $error("result word changed while stalled");

    // a result needs at least the pipe depth, so none right out of reset
    a_no_early_result: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result word right after reset");

endmodule

bind polygon_pole_containment ppc_checker u_ppc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (vertex.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .pole_code (result.pole_code),
    .saturated (result.saturated)
);
